@@ hw/rtl/plf_pkg.sv @@
// Shared types and constants for the PWM linear fade controller.
// Used by the channel interfaces, the controller, the datapath and the divider.
package plf_pkg;

	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned DUR_W    = 32;
	localparam int unsigned BW_W     = 5;
	localparam int unsigned TDIV_W   = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DELTA_W  = LEVEL_W + 1;

	// Shared restoring divider: 42-bit dividend, 32-bit divisor.
	localparam int unsigned DIV_NUM_W = 42;
	localparam int unsigned DIV_DEN_W = 32;
	localparam int unsigned DIV_CNT_W = 6;
	localparam int unsigned PERMILLE_W = 10;
	localparam int unsigned PROD_W = LEVEL_W + PERMILLE_W;

	localparam int unsigned PERMILLE_SCALE = 1000;
	localparam logic [BW_W-1:0] MAX_BW = BW_W'(LEVEL_W);

	// The scaled step is divided by 1000 as a multiply by ceil(2^36/1000),
	// keeping the bits from 36 up. This is exact for every product below 2^26.
	localparam int unsigned RECIP_W     = 27;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam logic [RECIP_W-1:0] PERMILLE_RECIP = RECIP_W'(68719477);

	localparam logic [DIV_CNT_W-1:0] TU_STEPS   = DIV_CNT_W'(DUR_W);
	localparam logic [DIV_CNT_W-1:0] PM_STEPS   = DIV_CNT_W'(DIV_NUM_W);

	typedef enum logic [1:0] {
		REQ_SET  = 2'd0,
		REQ_FADE = 2'd1,
		REQ_STOP = 2'd2,
		REQ_TICK = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIT_WIDTH    = 2'd0,
		CFG_INVERT       = 2'd1,
		CFG_TIME_DIVIDER = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DSEL_TU   = 2'd0,
		DSEL_PM   = 2'd1
	} div_sel_t;

	typedef struct packed {
		logic     set_level;
		logic     stop;
		logic     tick_inc;
		logic     div_start;
		div_sel_t div_sel;
		logic     fade_record;
		logic     calc_elapsed;
		logic     do_mul;
		logic     do_scale;
		logic     apply_step;
		logic     end_fade;
		logic     load_result;
	} ctrl_cmd_t;

	typedef struct packed {
		req_t req;
		logic dur_zero;
		logic fading;
		logic div_done;
		logic fade_cont;
	} dp_status_t;

endpackage

@@ hw/rtl/plf_req_if.sv @@
// Request channel of the PWM linear fade controller: valid/ready and one request.
// Depends on plf_pkg for the field widths.
interface plf_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic [plf_pkg::LEVEL_W-1:0]  target_value;
	logic [plf_pkg::DUR_W-1:0]    duration;

	modport source (output valid, req_type, target_value, duration, input ready);
	modport sink (input valid, req_type, target_value, duration, output ready);
endinterface

@@ hw/rtl/plf_res_if.sv @@
// Result channel of the PWM linear fade controller: valid/ready and one result.
// Depends on plf_pkg for the field widths.
interface plf_res_if;
	logic                         valid;
	logic                         ready;
	logic [plf_pkg::LEVEL_W-1:0]  pwm_level;
	logic [plf_pkg::LEVEL_W-1:0]  level_value;
	logic                         fade_running;

	modport source (output valid, pwm_level, level_value, fade_running, input ready);
	modport sink (input valid, pwm_level, level_value, fade_running, output ready);
endinterface

@@ hw/rtl/pwm_linear_fade_controller_top.sv @@
// Top level of the PWM linear fade controller.
// Depends on plf_pkg, plf_req_if, plf_res_if, plf_ctrl, plf_dp and plf_div.
//
// Usage: requests arrive on the request channel (valid/ready), one per transfer:
// set a level, start a fade, stop a fade, or a one-millisecond tick. Every
// request produces exactly one result transfer on the result channel carrying
// the pin duty level (inverted if configured), the plain level and whether a
// fade is still running. Configuration registers (bit width, invert, time
// divider) are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. A fade
// start and every tick during a fade use the shared one-bit-per-cycle divider
// (32 iterations for the time unit, 42 for the permille); a tick that does not end
// the fade also uses a registered reciprocal multiply for the division by 1000.
// One request is processed at a time; the next transfer can be accepted in the
// same cycle that result valid rises.
// Reset clears the level, fade state and millisecond count, and loads the
// register defaults (bit width 8, no inversion, divider 1).
// If the receiver stalls, the result waits in its output register; a further
// request is still accepted and processed, and then waits until that result
// transfer completes before its own result is loaded.
module pwm_linear_fade_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	plf_req_if.sink                         request,
	plf_res_if.source                       result,
	input  logic                            cfg_we,
	input  logic [plf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plf_pkg::CFG_W-1:0]       cfg_data
);

	plf_pkg::ctrl_cmd_t   cmd;
	plf_pkg::dp_status_t  status;
	logic                 req_xfer;

	// A request is captured into the datapath on its transfer.
	assign req_xfer = request.valid && request.ready;

	plf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	plf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_load    (req_xfer),
		.req_type     (request.req_type),
		.target_value (request.target_value),
		.duration     (request.duration),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.pwm_level    (result.pwm_level),
		.level_value  (result.level_value),
		.fade_running (result.fade_running)
	);

endmodule

@@ hw/rtl/plf_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on plf_pkg for widths. The time-unit dividend arrives left aligned.
module plf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [plf_pkg::DIV_NUM_W-1:0]   dividend,
	input  logic [plf_pkg::DIV_DEN_W-1:0]   divisor,
	input  logic [plf_pkg::DIV_CNT_W-1:0]   steps,
	output logic                            done,
	output logic [plf_pkg::DIV_NUM_W-1:0]   quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [plf_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [plf_pkg::DIV_DEN_W-1:0]   rem_q;
	logic [plf_pkg::DIV_DEN_W-1:0]   den_q;
	logic [plf_pkg::DIV_NUM_W-1:0]   quo_q;
	logic [plf_pkg::DIV_DEN_W:0]     rem_sh;
	logic [plf_pkg::DIV_DEN_W:0]     rem_sub;
	logic                            ge;

	// The partial remainder stays below the divisor, so 32 bits hold it.
	assign rem_sh  = {rem_q, quo_q[plf_pkg::DIV_NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == plf_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[plf_pkg::DIV_DEN_W-1:0] : rem_sh[plf_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[plf_pkg::DIV_NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/plf_dp.sv @@
// Datapath of the PWM linear fade controller: configuration, fade state,
// the shared divider and the result register. Depends on plf_pkg and plf_div.
module plf_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_load,
	input  logic [1:0]                      req_type,
	input  logic [plf_pkg::LEVEL_W-1:0]     target_value,
	input  logic [plf_pkg::DUR_W-1:0]       duration,
	input  logic                            cfg_we,
	input  logic [plf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plf_pkg::CFG_W-1:0]       cfg_data,
	input  plf_pkg::ctrl_cmd_t              cmd,
	output plf_pkg::dp_status_t             status,
	output logic [plf_pkg::LEVEL_W-1:0]     pwm_level,
	output logic [plf_pkg::LEVEL_W-1:0]     level_value,
	output logic                            fade_running
);

	localparam int unsigned LW = plf_pkg::LEVEL_W;
	localparam int unsigned SW = plf_pkg::PROD_W + plf_pkg::RECIP_W;

	// Configuration.
	logic [plf_pkg::BW_W-1:0]     bw_q;
	logic                         inv_q;
	logic [plf_pkg::TDIV_W-1:0]   tdiv_q;

	// Fade state.
	logic [LW-1:0]                level_q;
	logic                         fading_q;
	logic [plf_pkg::DUR_W-1:0]    ms_q;
	logic [plf_pkg::DUR_W-1:0]    start_time_q;
	logic [plf_pkg::DUR_W-1:0]    total_q;
	logic [LW-1:0]                start_level_q;
	logic [plf_pkg::DELTA_W-1:0]  delta_q;
	logic [LW-1:0]                end_level_q;

	// Item and intermediate values.
	logic [1:0]                   req_q;
	logic [LW-1:0]                target_q;
	logic [plf_pkg::DUR_W-1:0]    dur_q;
	logic [plf_pkg::DUR_W-1:0]    elapsed_q;
	logic [plf_pkg::PROD_W-1:0]   prod_mag_q;
	logic                         prod_neg_q;
	logic [LW-1:0]                step_q;

	logic [LW-1:0]                res_pin_q;
	logic [LW-1:0]                res_level_q;
	logic                         res_fading_q;

	logic [plf_pkg::BW_W-1:0]     bw_eff;
	logic [LW:0]                  one_sh;
	logic [LW:0]                  max17;
	logic [LW-1:0]                max_level;
	logic [LW-1:0]                tgt;
	logic [plf_pkg::TDIV_W-1:0]   tdiv_eff;
	logic [plf_pkg::DELTA_W-1:0]  delta_new;
	logic [plf_pkg::DELTA_W-1:0]  delta_mag;
	logic [LW:0]                  level_new;
	logic [LW-1:0]                pin;
	logic [SW-1:0]                scaled;

	logic [plf_pkg::DIV_NUM_W-1:0] div_num;
	logic [plf_pkg::DIV_DEN_W-1:0] div_den;
	logic [plf_pkg::DIV_CNT_W-1:0] div_steps;
	logic                          div_done;
	logic [plf_pkg::DIV_NUM_W-1:0] div_quo;

	assign bw_eff    = (bw_q > plf_pkg::MAX_BW) ? plf_pkg::MAX_BW : bw_q;
	assign one_sh    = (LW+1)'(1) << bw_eff;
	assign max17     = one_sh - (LW+1)'(1);
	assign max_level = max17[LW-1:0];
	assign tgt       = (target_q > max_level) ? max_level : target_q;
	assign tdiv_eff  = (tdiv_q == '0) ? plf_pkg::TDIV_W'(1) : tdiv_q;
	assign delta_new = {1'b0, tgt} - {1'b0, level_q};
	assign delta_mag = delta_q[plf_pkg::DELTA_W-1] ? (~delta_q + 1'b1) : delta_q;
	assign scaled    = SW'(prod_mag_q) * SW'(plf_pkg::PERMILLE_RECIP);
	assign level_new = prod_neg_q ? ({1'b0, start_level_q} - {1'b0, step_q})
	                              : ({1'b0, start_level_q} + {1'b0, step_q});

	always_comb begin
		if (inv_q) begin
			pin = (level_q > max_level) ? '0 : (max_level - level_q);
		end else begin
			pin = level_q;
		end
	end

	// Divider operand selection; the time-unit operand is left aligned in the dividend.
	always_comb begin
		case (cmd.div_sel)
			plf_pkg::DSEL_TU: begin
				div_num   = {ms_q, (plf_pkg::DIV_NUM_W - plf_pkg::DUR_W)'(0)};
				div_den   = plf_pkg::DIV_DEN_W'(tdiv_eff);
				div_steps = plf_pkg::TU_STEPS;
			end
			plf_pkg::DSEL_PM: begin
				div_num   = plf_pkg::DIV_NUM_W'(elapsed_q)
				          * plf_pkg::DIV_NUM_W'(plf_pkg::PERMILLE_SCALE);
				div_den   = total_q;
				div_steps = plf_pkg::PM_STEPS;
			end
			default: begin
				div_num   = '0;
				div_den   = plf_pkg::DIV_DEN_W'(1);
				div_steps = plf_pkg::TU_STEPS;
			end
		endcase
	end

	plf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q          <= plf_pkg::BW_W'(8);
			inv_q         <= 1'b0;
			tdiv_q        <= plf_pkg::TDIV_W'(1);
			level_q       <= '0;
			fading_q      <= 1'b0;
			ms_q          <= '0;
			start_time_q  <= '0;
			total_q       <= '0;
			start_level_q <= '0;
			delta_q       <= '0;
			end_level_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (plf_pkg::cfg_idx_t'(cfg_index))
					plf_pkg::CFG_BIT_WIDTH:    bw_q   <= cfg_data[plf_pkg::BW_W-1:0];
					plf_pkg::CFG_INVERT:       inv_q  <= cfg_data[0];
					plf_pkg::CFG_TIME_DIVIDER: tdiv_q <= cfg_data[plf_pkg::TDIV_W-1:0];
					default: ;
				endcase
			end
			if (cmd.set_level) begin
				level_q  <= tgt;
				fading_q <= 1'b0;
			end
			if (cmd.stop) begin
				fading_q <= 1'b0;
			end
			if (cmd.tick_inc) begin
				ms_q <= ms_q + 1'b1;
			end
			if (cmd.fade_record) begin
				start_time_q  <= div_quo[plf_pkg::DUR_W-1:0];
				total_q       <= dur_q;
				start_level_q <= level_q;
				delta_q       <= delta_new;
				end_level_q   <= tgt;
				fading_q      <= 1'b1;
			end
			if (cmd.apply_step) begin
				level_q <= level_new[LW-1:0];
			end
			if (cmd.end_fade) begin
				level_q  <= end_level_q;
				fading_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) begin
			req_q    <= req_type;
			target_q <= target_value;
			dur_q    <= duration;
		end
		if (cmd.calc_elapsed) begin
			elapsed_q <= div_quo[plf_pkg::DUR_W-1:0] - start_time_q;
		end
		if (cmd.do_mul) begin
			prod_mag_q <= plf_pkg::PROD_W'(delta_mag[LW-1:0])
			            * plf_pkg::PROD_W'(div_quo[plf_pkg::PERMILLE_W-1:0]);
			prod_neg_q <= delta_q[plf_pkg::DELTA_W-1];
		end
		if (cmd.do_scale) begin
			step_q <= scaled[plf_pkg::RECIP_SHIFT +: LW];
		end
		if (cmd.load_result) begin
			res_pin_q    <= pin;
			res_level_q  <= level_q;
			res_fading_q <= fading_q;
		end
	end

	assign status.req       = plf_pkg::req_t'(req_q);
	assign status.dur_zero  = (dur_q == '0);
	assign status.fading    = fading_q;
	assign status.div_done  = div_done;
	assign status.fade_cont = (total_q != '0) && (elapsed_q < total_q);

	assign pwm_level    = res_pin_q;
	assign level_value  = res_level_q;
	assign fade_running = res_fading_q;

endmodule

@@ hw/rtl/plf_ctrl.sv @@
// Controller of the PWM linear fade controller: sequences one request at a
// time through the datapath and owns the channel handshakes. Depends on plf_pkg.
module plf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  plf_pkg::dp_status_t   status,
	output plf_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FWAIT,
		S_TICK,
		S_TWAIT,
		S_ELAP,
		S_CHK,
		S_PWAIT,
		S_MUL,
		S_SCALE,
		S_FIN,
		S_RES
	} state_t;

	state_t              state_q;
	plf_pkg::ctrl_cmd_t  cmd_q;
	logic                out_valid_q;
	logic                div_ready;

	// The divider's done flag is stale in the cycle its start command is live.
	assign div_ready = !cmd_q.div_start && status.div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmd_q <= '0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (status.req)
						plf_pkg::REQ_SET: begin
							cmd_q.set_level <= 1'b1;
							state_q         <= S_FIN;
						end
						plf_pkg::REQ_FADE: begin
							if (status.dur_zero) begin
								cmd_q.set_level <= 1'b1;
								state_q         <= S_FIN;
							end else begin
								cmd_q.div_start <= 1'b1;
								cmd_q.div_sel   <= plf_pkg::DSEL_TU;
								state_q         <= S_FWAIT;
							end
						end
						plf_pkg::REQ_STOP: begin
							cmd_q.stop <= 1'b1;
							state_q    <= S_FIN;
						end
						default: begin
							cmd_q.tick_inc <= 1'b1;
							state_q        <= S_TICK;
						end
					endcase
				end
				S_FWAIT: begin
					if (div_ready) begin
						cmd_q.fade_record <= 1'b1;
						state_q           <= S_FIN;
					end
				end
				S_TICK: begin
					if (status.fading) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= plf_pkg::DSEL_TU;
						state_q         <= S_TWAIT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_TWAIT: begin
					if (div_ready) begin
						cmd_q.calc_elapsed <= 1'b1;
						state_q            <= S_ELAP;
					end
				end
				S_ELAP: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (status.fade_cont) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= plf_pkg::DSEL_PM;
						state_q         <= S_PWAIT;
					end else begin
						cmd_q.end_fade <= 1'b1;
						state_q        <= S_FIN;
					end
				end
				S_PWAIT: begin
					if (div_ready) begin
						cmd_q.do_mul <= 1'b1;
						state_q      <= S_MUL;
					end
				end
				S_MUL: begin
					cmd_q.do_scale <= 1'b1;
					state_q        <= S_SCALE;
				end
				S_SCALE: begin
					cmd_q.apply_step <= 1'b1;
					state_q          <= S_FIN;
				end
				S_FIN: begin
					// Wait until the result register is free or being emptied.
					if (!out_valid_q || out_ready) begin
						cmd_q.load_result <= 1'b1;
						state_q           <= S_RES;
					end
				end
				S_RES: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd       = cmd_q;

endmodule
